// ===== rtl/mm_pkg.sv =====
// Shared types and constants of the matrix multiply block.
package mm_pkg;

  localparam int MaxDim    = 8;
  localparam int ElemWidth = 16;
  localparam int AccWidth  = 40;
  localparam int IdxWidth  = 3;
  localparam int DimWidth  = 4;
  localparam int FifoDepth = 2;

  typedef enum logic [1:0] {
    ACT_LOAD_LEFT  = 2'd0,
    ACT_LOAD_RIGHT = 2'd1,
    ACT_START      = 2'd2,
    ACT_NONE       = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    REG_LEFT_ROWS  = 2'd0,
    REG_INNER_SIZE = 2'd1,
    REG_RIGHT_COLS = 2'd2
  } reg_idx_e;

  // Command passed from front end to back end: a start request.
  typedef struct packed {
    logic [DimWidth-1:0] nr;
    logic [DimWidth-1:0] nk;
    logic [DimWidth-1:0] nc;
  } cmd_t;

  function automatic logic [DimWidth-1:0] clamp_dim(logic [DimWidth-1:0] d, int max_dim);
    logic [DimWidth-1:0] r;
    r = d;
    if (d == '0) r = DimWidth'(1);
    else if (32'(d) > max_dim) r = DimWidth'(max_dim);
    return r;
  endfunction

endpackage

// ===== rtl/mm_ram.sv =====
// Generic single-port-write, registered-read RAM.
module mm_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== rtl/mm_front.sv =====
// Front end: classifies incoming words, performs loads, queues start commands.
module mm_front #(
  parameter int MaxDimP    = mm_pkg::MaxDim,
  parameter int ElemWidthP = mm_pkg::ElemWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mm_pkg::DimWidth-1:0]   cfg_idx_i,
  input  logic [mm_pkg::DimWidth-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    in_action_i,
  input  logic [mm_pkg::IdxWidth-1:0]   in_row_i,
  input  logic [mm_pkg::IdxWidth-1:0]   in_col_i,
  input  logic signed [15:0]            in_elem_i,
  output logic                          left_we_o,
  output logic                          right_we_o,
  output logic [$clog2(MaxDimP*MaxDimP)-1:0] waddr_o,
  output logic [ElemWidthP-1:0]         wdata_o,
  output logic                          cmd_valid_o,
  input  logic                          cmd_ready_i,
  output mm_pkg::cmd_t                  cmd_o,
  input  logic                          busy_i
);
  import mm_pkg::*;

  localparam int AW = $clog2(MaxDimP*MaxDimP);
  localparam int PW = $clog2(FifoDepth);

  logic [DimWidth-1:0] rows_q, inner_q, cols_q;
  cmd_t fifo_q [FifoDepth];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0] cnt_q;
  logic acc, is_start, in_range, push, pop;
  logic [ElemWidthP+15:0] ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= DimWidth'(MaxDim);
      inner_q <= DimWidth'(MaxDim);
      cols_q  <= DimWidth'(MaxDim);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        DimWidth'(REG_LEFT_ROWS):  rows_q  <= cfg_data_i;
        DimWidth'(REG_INNER_SIZE): inner_q <= cfg_data_i;
        DimWidth'(REG_RIGHT_COLS): cols_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Hold starts while the queue is full; hold other words until every queued
  // or running multiply has finished reading the stores.
  assign is_start = (in_action_i == ACT_START);
  assign in_ready_o = is_start ? (cnt_q != (PW+1)'(FifoDepth)) :
                                 ((cnt_q == '0) && !busy_i);
  assign acc = in_valid_i && in_ready_o;
  assign in_range = (32'(in_row_i) < MaxDimP) && (32'(in_col_i) < MaxDimP);
  assign left_we_o  = acc && in_range && (in_action_i == ACT_LOAD_LEFT);
  assign right_we_o = acc && in_range && (in_action_i == ACT_LOAD_RIGHT);
  assign waddr_o = AW'(32'(in_row_i) * MaxDimP + 32'(in_col_i));
  assign ext = {{ElemWidthP{in_elem_i[15]}}, in_elem_i};
  assign wdata_o = ext[ElemWidthP-1:0];

  assign push = acc && is_start;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop = cmd_valid_o && cmd_ready_i;
  assign cmd_o = fifo_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= '{nr: clamp_dim(rows_q, MaxDimP),
                                nk: clamp_dim(inner_q, MaxDimP),
                                nc: clamp_dim(cols_q, MaxDimP)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= PW'(wp_q + 1'b1);
      if (pop)  rp_q <= PW'(rp_q + 1'b1);
      cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
    end
  end
endmodule

// ===== rtl/mm_back.sv =====
// Back end: walks the product, one MAC per cycle while issuing.
module mm_back #(
  parameter int MaxDimP    = mm_pkg::MaxDim,
  parameter int ElemWidthP = mm_pkg::ElemWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  output logic                          cmd_ready_o,
  input  mm_pkg::cmd_t                  cmd_i,
  output logic [$clog2(MaxDimP*MaxDimP)-1:0] laddr_o,
  output logic [$clog2(MaxDimP*MaxDimP)-1:0] raddr_o,
  input  logic [ElemWidthP-1:0]         ldata_i,
  input  logic [ElemWidthP-1:0]         rdata_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mm_pkg::IdxWidth-1:0]   out_row_o,
  output logic [mm_pkg::IdxWidth-1:0]   out_col_o,
  output logic [mm_pkg::AccWidth-1:0]   out_value_o,
  output logic                          out_last_o,
  output logic                          busy_o
);
  import mm_pkg::*;

  localparam int AW = $clog2(MaxDimP*MaxDimP);
  localparam int PW = 2*ElemWidthP;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_OUT  = 3'b100
  } state_e;

  state_e state_q, state_d;
  cmd_t cmd_q;
  logic [IdxWidth-1:0] i_q, j_q, k_q;
  logic rd_v_q, mul_v_q, rd_last_q, mul_last_q;
  logic signed [PW-1:0] prod_q;
  logic [AccWidth-1:0] acc_q;
  logic k_end, j_end, i_end;
  logic signed [PW-1:0] prod_d;

  assign k_end = (4'(k_q) == cmd_q.nk - 4'd1);
  assign j_end = (4'(j_q) == cmd_q.nc - 4'd1);
  assign i_end = (4'(i_q) == cmd_q.nr - 4'd1);

  assign laddr_o = AW'(32'(i_q) * MaxDimP + 32'(k_q));
  assign raddr_o = AW'(32'(k_q) * MaxDimP + 32'(j_q));
  assign prod_d = $signed(ldata_i) * $signed(rdata_i);

  assign cmd_ready_o = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign busy_o = (state_q != S_IDLE);

  logic issuing;
  assign issuing = (state_q == S_RUN) && !rd_last_q && !mul_last_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (cmd_valid_i) state_d = S_RUN;
      S_RUN:  if (mul_v_q && mul_last_q) state_d = S_OUT;
      S_OUT:  if (out_ready_i) state_d = (i_end && j_end) ? S_IDLE : S_RUN;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rd_v_q <= 1'b0; mul_v_q <= 1'b0; rd_last_q <= 1'b0; mul_last_q <= 1'b0;
      i_q <= '0; j_q <= '0; k_q <= '0; cmd_q <= '0;
    end else begin
      state_q <= state_d;
      rd_v_q <= issuing;
      rd_last_q <= issuing && k_end;
      mul_v_q <= rd_v_q;
      mul_last_q <= rd_last_q;
      case (state_q)
        S_IDLE: if (cmd_valid_i) begin
          cmd_q <= cmd_i; i_q <= '0; j_q <= '0; k_q <= '0;
        end
        S_RUN: if (issuing) k_q <= k_end ? '0 : IdxWidth'(k_q + 1'b1);
        S_OUT: if (out_ready_i) begin
          if (j_end) begin
            j_q <= '0; i_q <= IdxWidth'(i_q + 1'b1);
          end else begin
            j_q <= IdxWidth'(j_q + 1'b1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_v_q) prod_q <= prod_d;
    if (state_q == S_OUT && out_ready_i) acc_q <= '0;
    else if (state_q == S_IDLE) acc_q <= '0;
    else if (mul_v_q) acc_q <= acc_q + AccWidth'(prod_q);
  end

  assign out_row_o = i_q;
  assign out_col_o = j_q;
  assign out_value_o = acc_q;
  assign out_last_o = i_end && j_end;
endmodule

// ===== rtl/matrix_multiply_top.sv =====
// Top level of the matrix multiply block.
// Load words are taken one per cycle but wait while a start is queued or a
// multiply is running, so a run always sees the stores as they were when it
// was started; start words queue up to two deep. A start word produces
// left_rows*right_cols product words; each product is computed by the single
// multiply-accumulate unit, which reads one left and one right entry per
// cycle while it runs and pauses while each product word is handed out.
module matrix_multiply_top #(
  parameter int MaxDimP    = mm_pkg::MaxDim,
  parameter int ElemWidthP = mm_pkg::ElemWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_idx_i,
  input  logic [3:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // action[1:0], row_index[4:2], col_index[7:5], element[23:8]
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_row[2:0], out_col[5:3], product_value[45:6], zero pad
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tlast
);
  import mm_pkg::*;

  localparam int AW = $clog2(MaxDimP*MaxDimP);

  logic lwe, rwe, cmd_v, cmd_r, busy;
  logic [AW-1:0] waddr, laddr, raddr;
  logic [ElemWidthP-1:0] wdata, ldata, rdata;
  cmd_t cmd;
  logic [IdxWidth-1:0] orow, ocol;
  logic [AccWidth-1:0] oval;

  mm_front #(.MaxDimP(MaxDimP), .ElemWidthP(ElemWidthP)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_action_i(s_axis_tdata[1:0]), .in_row_i(s_axis_tdata[4:2]),
    .in_col_i(s_axis_tdata[7:5]), .in_elem_i(s_axis_tdata[23:8]),
    .left_we_o(lwe), .right_we_o(rwe), .waddr_o(waddr), .wdata_o(wdata),
    .cmd_valid_o(cmd_v), .cmd_ready_i(cmd_r), .cmd_o(cmd), .busy_i(busy)
  );

  mm_ram #(.Width(ElemWidthP), .Depth(MaxDimP*MaxDimP)) u_left (
    .clk_i, .we_i(lwe), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(laddr), .rdata_o(ldata)
  );

  mm_ram #(.Width(ElemWidthP), .Depth(MaxDimP*MaxDimP)) u_right (
    .clk_i, .we_i(rwe), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  mm_back #(.MaxDimP(MaxDimP), .ElemWidthP(ElemWidthP)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_v), .cmd_ready_o(cmd_r), .cmd_i(cmd),
    .laddr_o(laddr), .raddr_o(raddr), .ldata_i(ldata), .rdata_i(rdata),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_row_o(orow), .out_col_o(ocol), .out_value_o(oval),
    .out_last_o(m_axis_tlast), .busy_o(busy)
  );

  assign m_axis_tdata = {2'b00, oval, ocol, orow};
endmodule

// ===== rtl/mm_checker.sv =====
// Port-level checker for the matrix multiply block, bound to the top level.
module mm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[47:46] == 2'b00)
    else $error("pad bits set");

  a_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast
    |=> !m_axis_tvalid || (m_axis_tdata[5:0] == 6'd0) || $past(m_axis_tdata[5:0]) == 6'd0)
    else $error("run did not restart at origin");
endmodule

bind matrix_multiply_top mm_checker u_mm_checker (
  .clk_i, .rst_ni, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
);
